/* rtl/trc_pkg.sv */
// Shared constants and types for the timestamp reorder cache.
// Used by timestamp_reorder_cache and by its port checker; no dependencies.
`default_nettype none

package trc_pkg;

   localparam int CAPACITY  = 16;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int FILL_W    = 5;
   localparam int STAMP_W   = 64;
   localparam int PAYLOAD_W = 64;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_TAKE_MIN = 2'd1,
      OP_TAKE_KEY = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

endpackage

`default_nettype wire

/* rtl/timestamp_reorder_cache.sv */
// Timestamp reorder cache: table of CAPACITY stamp/payload entries, kept in order.
// Depends on trc_pkg.
//
// Usage: one request (opcode, key_stamp, entry_payload) on the req_ channel gives
// exactly one response on the rsp_ channel. Both use valid/ready; a request is
// taken when req_valid and req_ready are high at a clock edge, likewise rsp_.
// A request is worked on alone; req_ready is high only while the sequencer idles.
// Steps by request: a clear, and a take on an empty table, go straight to the finish
// state; a push on a table with room appends; a take by timestamp runs one
// compaction pass; a take smallest runs a min scan and then a compaction pass, and
// a push on a full table does the same and then appends.
// Both passes run through the entry memory (one read, one write port) at one entry a
// cycle, and one signed 64-bit comparator serves the min search and the key match.
// The response sits in an output register; a new request may be taken while it
// waits, and the next result then holds in the finish state until rsp_ready.
// Reset (synchronous, active high) empties the table and drops any pending
// response; the entry memory itself is not cleared and needs no clearing pass.
`default_nettype none

module timestamp_reorder_cache (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic signed [trc_pkg::STAMP_W-1:0]   req_key_stamp,
   input  wire logic [trc_pkg::PAYLOAD_W-1:0]        req_entry_payload,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_found,
   output      logic signed [trc_pkg::STAMP_W-1:0]   rsp_out_stamp,
   output      logic [trc_pkg::PAYLOAD_W-1:0]        rsp_out_payload,
   output      logic                                 rsp_overflow_evicted,
   output      logic [trc_pkg::FILL_W-1:0]           rsp_fill_count
);
   import trc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_COMPACT = 5'b00100,
      ST_APPEND  = 5'b01000,
      ST_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic signed [STAMP_W-1:0]   key_ff, key_in;
   logic [PAYLOAD_W-1:0]        pay_ff, pay_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]            wr_idx_ff, wr_idx_in;
   logic                        dv_ff, dv_in;
   logic [ADDR_W-1:0]           dat_idx_ff, dat_idx_in;
   logic [ADDR_W-1:0]           best_idx_ff, best_idx_in;
   logic signed [STAMP_W-1:0]   best_stamp_ff, best_stamp_in;
   logic [PAYLOAD_W-1:0]        best_pay_ff, best_pay_in;
   logic                        match_ff, match_in;
   logic                        found_ff, found_in;
   logic                        evict_ff, evict_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic signed [STAMP_W-1:0]   rsp_stamp_ff, rsp_stamp_in;
   logic [PAYLOAD_W-1:0]        rsp_pay_ff, rsp_pay_in;
   logic                        rsp_evict_ff, rsp_evict_in;
   logic [FILL_W-1:0]           rsp_fill_ff, rsp_fill_in;

   // entry memory, registered read
   logic signed [STAMP_W-1:0]   stamp_mem [CAPACITY];
   logic [PAYLOAD_W-1:0]        payload_mem [CAPACITY];
   logic signed [STAMP_W-1:0]   rd_stamp_ff;
   logic [PAYLOAD_W-1:0]        rd_pay_ff;

   logic                        rd_en;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic signed [STAMP_W-1:0]   wr_stamp;
   logic [PAYLOAD_W-1:0]        wr_pay;

   logic signed [STAMP_W-1:0]   cmp_op;
   logic                        stamp_lt;
   logic                        stamp_eq;
   logic                        last;
   logic                        drop;

   // the one shared comparator: against running minimum in scan, against key otherwise
   assign cmp_op   = (state_ff == ST_SCAN) ? best_stamp_ff : key_ff;
   assign stamp_lt = rd_stamp_ff < cmp_op;
   assign stamp_eq = rd_stamp_ff == cmp_op;
   assign last     = dv_ff && (dat_idx_ff == ADDR_W'(count_ff - 1'b1));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      wr_idx_in     = wr_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_pay_in   = best_pay_ff;
      match_in      = match_ff;
      found_in      = found_ff;
      evict_in      = evict_ff;
      drop          = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = wr_idx_ff[ADDR_W-1:0];
      wr_stamp      = rd_stamp_ff;
      wr_pay        = rd_pay_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_stamp_in  = rsp_stamp_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_fill_in   = rsp_fill_ff;

      // read issue, shared by both passes
      rd_en      = ((state_ff == ST_SCAN) || (state_ff == ST_COMPACT)) &&
                   (rd_idx_ff < count_ff);
      rd_idx_in  = rd_en ? rd_idx_ff + 1'b1 : rd_idx_ff;
      dv_in      = rd_en;
      dat_idx_in = rd_idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            wr_idx_in = '0;
            if (req_valid) begin
               op_in    = op_type'(req_opcode);
               key_in   = req_key_stamp;
               pay_in   = req_entry_payload;
               found_in = 1'b0;
               evict_in = 1'b0;
               match_in = 1'b0;
               unique case (op_type'(req_opcode))
                  OP_PUSH: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        state_in = ST_APPEND;
                     end else begin
                        evict_in = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_TAKE_MIN: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
                  OP_TAKE_KEY: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_COMPACT;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            // strict less-than keeps the earliest entry on ties
            if (dv_ff && ((dat_idx_ff == '0) || stamp_lt)) begin
               best_idx_in   = dat_idx_ff;
               best_stamp_in = rd_stamp_ff;
               best_pay_in   = rd_pay_ff;
            end
            if (last) begin
               rd_idx_in = '0;
               wr_idx_in = '0;
               found_in  = (op_ff == OP_TAKE_MIN);
               state_in  = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            if (dv_ff) begin
               if (op_ff == OP_TAKE_KEY) begin
                  // drop entries below the key up to and including the first match
                  drop = !match_ff && (stamp_lt || stamp_eq);
                  if (!match_ff && stamp_eq) begin
                     match_in      = 1'b1;
                     found_in      = 1'b1;
                     best_stamp_in = rd_stamp_ff;
                     best_pay_in   = rd_pay_ff;
                  end
               end else begin
                  drop = (dat_idx_ff == best_idx_ff);
               end
               if (!drop) begin
                  wr_en     = 1'b1;
                  wr_idx_in = wr_idx_ff + 1'b1;
               end
               if (last) begin
                  count_in = drop ? wr_idx_ff : wr_idx_ff + 1'b1;
                  state_in = (op_ff == OP_PUSH) ? ST_APPEND : ST_FINISH;
               end
            end
         end
         ST_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[ADDR_W-1:0];
            wr_stamp = key_ff;
            wr_pay   = pay_ff;
            count_in = count_ff + 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_stamp_in = found_ff ? best_stamp_ff : '0;
               rsp_pay_in   = found_ff ? best_pay_ff : '0;
               rsp_evict_in = evict_ff;
               rsp_fill_in  = FILL_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      dat_idx_ff    <= dat_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_pay_ff   <= best_pay_in;
      match_ff      <= match_in;
      found_ff      <= found_in;
      evict_ff      <= evict_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_stamp_ff  <= rsp_stamp_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // in the compaction pass, writes land at or below the entry just read, never ahead of the read pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[wr_addr]   <= wr_stamp;
         payload_mem[wr_addr] <= wr_pay;
      end
      if (rd_en) begin
         rd_stamp_ff <= stamp_mem[rd_idx_ff[ADDR_W-1:0]];
         rd_pay_ff   <= payload_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_out_stamp        = rsp_stamp_ff;
   assign rsp_out_payload      = rsp_pay_ff;
   assign rsp_overflow_evicted = rsp_evict_ff;
   assign rsp_fill_count       = rsp_fill_ff;

endmodule

`default_nettype wire

/* rtl/trc_checker.sv */
// Port-level checks for timestamp_reorder_cache, bound to the top level.
// Depends on trc_pkg.
`default_nettype none

module trc_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic                                 rsp_found,
   input wire logic signed [trc_pkg::STAMP_W-1:0]   rsp_out_stamp,
   input wire logic [trc_pkg::PAYLOAD_W-1:0]        rsp_out_payload,
   input wire logic                                 rsp_overflow_evicted,
   input wire logic [trc_pkg::FILL_W-1:0]           rsp_fill_count
);
   import trc_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_stamp) &&
      $stable(rsp_out_payload) && $stable(rsp_found) && $stable(rsp_fill_count))
      else $error("response changed while stalled");

   // a miss returns zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_out_stamp == '0 && rsp_out_payload == '0)
      else $error("non-zero fields on a miss");

   // an eviction comes from a push, which never returns an entry
   a_evict_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_evicted |-> !rsp_found)
      else $error("eviction flagged on a take");

   // after an eviction the table is full again
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_evicted |-> rsp_fill_count == FILL_W'(CAPACITY))
      else $error("eviction left the table short");

   // the table never reports more than its capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 31) || (rsp_fill_count <= FILL_W'(CAPACITY)))
      else $error("fill count above capacity");

endmodule

bind timestamp_reorder_cache trc_checker u_trc_checker (.*);

`default_nettype wire
